@@ design/dbbm_pkg.sv @@
`default_nettype none

package dbbm_pkg;

    // Frame averaging
    localparam int MAX_FRAMES  = 4;
    localparam int NUM_SAMPLES = 4;
    localparam int FC_W        = 3;
    localparam int SUM_W       = 18;
    localparam int DEPTH_W     = 16;
    localparam int PIX_W       = 12;
    localparam int MAXD_W      = 13;
    localparam int BOX_W       = 13;
    localparam int LIM_W       = 20;

    // Back-projection divide
    localparam int DIFF_W  = 22;
    localparam int PROD1_W = DIFF_W + SUM_W;
    localparam int NUM_W   = 46;
    localparam int DEN_W   = 26;
    localparam int Q_W     = 19;
    localparam int PC_W    = Q_W + 1;

    // Pinhole intrinsics in fixed point
    localparam int CX_MILLI = 953567;
    localparam int CY_MILLI = 532635;
    localparam int FX_DEN   = 13822300;
    localparam int FY_DEN   = 13794600;
    localparam int Z_DEN    = 10;

    // Transform
    localparam int COEF_W     = 32;
    localparam int NUM_COEF   = 12;
    localparam int COEF_IDX_W = 4;
    localparam int ONE_Q16    = 65536;
    localparam int PROD_W     = COEF_W + PC_W;
    localparam int ACC_W      = PROD_W + 3;
    localparam int FRAC_W     = 16;
    localparam int RND_W      = ACC_W - FRAC_W;
    localparam int COORD_W    = 24;
    localparam int XF_LAT     = 4;

    // Stream packing
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 120;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_COUNT = 3'd0,
        REG_MAX_DEPTH   = 3'd1,
        REG_BOX_X_MIN   = 3'd2,
        REG_BOX_Y_MAX   = 3'd3,
        REG_BOX_Z_MIN   = 3'd4
    } cfg_reg_t;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_COEF  = 1'b1;

    // Item state carried beside the dividers
    typedef struct packed {
        logic [PIX_W-1:0]      col;
        logic [PIX_W-1:0]      row;
        logic                  ok;
        logic                  valid;
        logic                  is_coef;
        logic [COEF_IDX_W-1:0] idx;
        logic [COEF_W-1:0]     val;
    } side_t;

    // Item state carried beside the transform lanes
    typedef struct packed {
        logic [PIX_W-1:0]   col;
        logic [PIX_W-1:0]   row;
        logic               ok;
        logic               valid;
        logic [DEPTH_W-1:0] avg;
    } post_t;

endpackage

`default_nettype wire

@@ design/depth_backproject_box_mask.sv @@
`default_nettype none

// Path from the edge accepting a pixel beat to its result beat, stalls aside: front stage,
// numerator stage, 19 divider stages, four transform lane stages and the output register.
// Throughput: one beat per cycle unless the output beat is held; the divider pipelines and
// the three lanes take a new item every cycle. Coefficient writes take one slot and produce
// no result. Reset (rst_n, asynchronous, active low) clears valid bits, restores register
// defaults and loads the identity transform.
module depth_backproject_box_mask (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // col, row, depth_0..depth_3, coef_index, coef_value (lowest bit first)
    input  wire logic [dbbm_pkg::IN_DATA_W-1:0]      s_tdata,
    // cmd
    input  wire logic                                s_tuser,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // out_col, out_row, depth_valid, avg_depth, obj_x, obj_y, obj_z, inside_box
    output logic [dbbm_pkg::OUT_DATA_W-1:0]          m_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic                                cfg_we,
    input  wire logic [dbbm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dbbm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Configuration registers
    logic [dbbm_pkg::FC_W-1:0]          frame_count_reg;
    logic [dbbm_pkg::MAXD_W-1:0]        max_depth_reg;
    logic signed [dbbm_pkg::BOX_W-1:0]  box_x_min_reg;
    logic signed [dbbm_pkg::BOX_W-1:0]  box_y_max_reg;
    logic signed [dbbm_pkg::BOX_W-1:0]  box_z_min_reg;
    logic [dbbm_pkg::COEF_W-1:0]        coef_reg [dbbm_pkg::NUM_COEF];

    // Input skid
    logic                               skid_vld_reg;
    logic [dbbm_pkg::IN_DATA_W-1:0]     skid_data_reg;
    logic                               skid_user_reg;
    logic                               pipe_en;
    logic                               src_vld;
    logic [dbbm_pkg::IN_DATA_W-1:0]     src_data;
    logic                               src_user;

    // Front stage
    logic [dbbm_pkg::FC_W-1:0]          n_c;
    logic [dbbm_pkg::SUM_W-1:0]         sum_c;
    logic                               ok_c;
    logic                               deep_c;
    logic [dbbm_pkg::LIM_W-1:0]         lim_c;
    logic [dbbm_pkg::DIFF_W-1:0]        ux_c, vy_c;
    logic [dbbm_pkg::DEPTH_W-1:0]       d_c;

    logic                               s0_vld_reg;
    dbbm_pkg::side_t                    s0_side_reg;
    logic [dbbm_pkg::FC_W-1:0]          s0_n_reg;
    logic [dbbm_pkg::SUM_W-1:0]         s0_sum_reg;
    logic [dbbm_pkg::DIFF_W-1:0]        s0_xmag_reg, s0_ymag_reg;
    logic                               s0_xneg_reg, s0_yneg_reg;

    // Divider inputs
    logic [dbbm_pkg::NUM_W-1:0]         numx_reg, numy_reg, numz_reg, numa_reg;
    logic [dbbm_pkg::DEN_W-1:0]         denx_reg, deny_reg, denz_reg, dena_reg;
    logic                               negx_reg, negy_reg;
    logic [dbbm_pkg::PROD1_W-1:0]       px_c, py_c;
    logic [dbbm_pkg::DEN_W-1:0]         denx_c, deny_c, denz_c;

    logic                               side_vld_reg [dbbm_pkg::Q_W+1];
    dbbm_pkg::side_t                    side_reg [dbbm_pkg::Q_W+1];

    logic signed [dbbm_pkg::PC_W-1:0]   q_x, q_y, q_z, q_a;

    logic                               post_vld_reg [dbbm_pkg::XF_LAT];
    dbbm_pkg::post_t                    post_reg [dbbm_pkg::XF_LAT];

    logic [2:0][dbbm_pkg::PC_W-1:0]     pc_vec;
    logic signed [dbbm_pkg::COORD_W-1:0] obj [3];
    dbbm_pkg::side_t                    side_out;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= dbbm_pkg::FC_W'(1);
            max_depth_reg   <= dbbm_pkg::MAXD_W'(1500);
            box_x_min_reg   <= dbbm_pkg::BOX_W'(-60);
            box_y_max_reg   <= dbbm_pkg::BOX_W'(30);
            box_z_min_reg   <= dbbm_pkg::BOX_W'(390);
        end
        else if (cfg_we)
        begin
            case (dbbm_pkg::cfg_reg_t'(cfg_index))
                dbbm_pkg::REG_FRAME_COUNT: frame_count_reg <= cfg_data[dbbm_pkg::FC_W-1:0];
                dbbm_pkg::REG_MAX_DEPTH:   max_depth_reg   <= cfg_data;
                dbbm_pkg::REG_BOX_X_MIN:   box_x_min_reg   <= $signed(cfg_data);
                dbbm_pkg::REG_BOX_Y_MAX:   box_y_max_reg   <= $signed(cfg_data);
                dbbm_pkg::REG_BOX_Z_MIN:   box_z_min_reg   <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // Pipeline advances unless the output beat is held
    assign pipe_en  = m_tready || !m_tvalid;
    assign s_tready = !skid_vld_reg;

    // Park an input beat while the pipeline is held
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_vld_reg <= 1'b0;
        else if (pipe_en)
            skid_vld_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            skid_vld_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!pipe_en && s_tvalid && s_tready)
        begin
            skid_data_reg <= s_tdata;
            skid_user_reg <= s_tuser;
        end
    end

    assign src_vld  = skid_vld_reg || s_tvalid;
    assign src_data = skid_vld_reg ? skid_data_reg : s_tdata;
    assign src_user = skid_vld_reg ? skid_user_reg : s_tuser;

    // Frame count clamp, sample sum, zero and depth checks
    always_comb
    begin
        if (frame_count_reg == '0)
            n_c = dbbm_pkg::FC_W'(1);
        else if (frame_count_reg > dbbm_pkg::FC_W'(dbbm_pkg::MAX_FRAMES))
            n_c = dbbm_pkg::FC_W'(dbbm_pkg::MAX_FRAMES);
        else
            n_c = frame_count_reg;
        if (n_c > dbbm_pkg::FC_W'(dbbm_pkg::NUM_SAMPLES))
            n_c = dbbm_pkg::FC_W'(dbbm_pkg::NUM_SAMPLES);

        sum_c = '0;
        ok_c  = 1'b1;
        d_c   = '0;
        for (int i = 0; i < dbbm_pkg::NUM_SAMPLES; i++)
        begin
            d_c = src_data[2*dbbm_pkg::PIX_W + dbbm_pkg::DEPTH_W*i +: dbbm_pkg::DEPTH_W];
            if (dbbm_pkg::FC_W'(i) < n_c)
            begin
                sum_c = sum_c + dbbm_pkg::SUM_W'(d_c);
                if (d_c == '0)
                    ok_c = 1'b0;
            end
        end

        lim_c  = dbbm_pkg::LIM_W'(max_depth_reg) * dbbm_pkg::LIM_W'(n_c)
               * dbbm_pkg::LIM_W'(10);
        deep_c = dbbm_pkg::LIM_W'(sum_c) > lim_c;

        ux_c = dbbm_pkg::DIFF_W'(src_data[dbbm_pkg::PIX_W-1:0]) * dbbm_pkg::DIFF_W'(1000);
        vy_c = dbbm_pkg::DIFF_W'(src_data[2*dbbm_pkg::PIX_W-1:dbbm_pkg::PIX_W])
             * dbbm_pkg::DIFF_W'(1000);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_vld_reg <= 1'b0;
        else if (pipe_en)
            s0_vld_reg <= src_vld;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s0_side_reg.col     <= src_data[dbbm_pkg::PIX_W-1:0];
            s0_side_reg.row     <= src_data[2*dbbm_pkg::PIX_W-1:dbbm_pkg::PIX_W];
            s0_side_reg.ok      <= ok_c;
            s0_side_reg.valid   <= ok_c && !deep_c;
            s0_side_reg.is_coef <= (src_user == dbbm_pkg::CMD_COEF);
            s0_side_reg.idx     <= src_data[91:88];
            s0_side_reg.val     <= src_data[123:92];
            s0_n_reg            <= n_c;
            s0_sum_reg          <= sum_c;
            s0_xneg_reg         <= ux_c < dbbm_pkg::DIFF_W'(dbbm_pkg::CX_MILLI);
            s0_xmag_reg         <= (ux_c < dbbm_pkg::DIFF_W'(dbbm_pkg::CX_MILLI))
                                 ? dbbm_pkg::DIFF_W'(dbbm_pkg::CX_MILLI) - ux_c
                                 : ux_c - dbbm_pkg::DIFF_W'(dbbm_pkg::CX_MILLI);
            s0_yneg_reg         <= vy_c < dbbm_pkg::DIFF_W'(dbbm_pkg::CY_MILLI);
            s0_ymag_reg         <= (vy_c < dbbm_pkg::DIFF_W'(dbbm_pkg::CY_MILLI))
                                 ? dbbm_pkg::DIFF_W'(dbbm_pkg::CY_MILLI) - vy_c
                                 : vy_c - dbbm_pkg::DIFF_W'(dbbm_pkg::CY_MILLI);
        end
    end

    // Form numerators and divisors; x, y and z get a half-divisor rounding bias
    always_comb
    begin
        px_c   = dbbm_pkg::PROD1_W'(s0_xmag_reg) * dbbm_pkg::PROD1_W'(s0_sum_reg);
        py_c   = dbbm_pkg::PROD1_W'(s0_ymag_reg) * dbbm_pkg::PROD1_W'(s0_sum_reg);
        denx_c = dbbm_pkg::DEN_W'(s0_n_reg) * dbbm_pkg::DEN_W'(dbbm_pkg::FX_DEN);
        deny_c = dbbm_pkg::DEN_W'(s0_n_reg) * dbbm_pkg::DEN_W'(dbbm_pkg::FY_DEN);
        denz_c = dbbm_pkg::DEN_W'(s0_n_reg) * dbbm_pkg::DEN_W'(dbbm_pkg::Z_DEN);
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            numx_reg <= (dbbm_pkg::NUM_W'(px_c) << 4) + dbbm_pkg::NUM_W'(denx_c >> 1);
            numy_reg <= (dbbm_pkg::NUM_W'(py_c) << 4) + dbbm_pkg::NUM_W'(deny_c >> 1);
            numz_reg <= (dbbm_pkg::NUM_W'(s0_sum_reg) << 4) + dbbm_pkg::NUM_W'(denz_c >> 1);
            numa_reg <= dbbm_pkg::NUM_W'(s0_sum_reg);
            denx_reg <= denx_c;
            deny_reg <= deny_c;
            denz_reg <= denz_c;
            dena_reg <= dbbm_pkg::DEN_W'(s0_n_reg);
            negx_reg <= s0_xneg_reg;
            negy_reg <= s0_yneg_reg;
        end
    end

    // Item state travels beside the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= dbbm_pkg::Q_W; k++)
                side_vld_reg[k] <= 1'b0;
        end
        else if (pipe_en)
        begin
            side_vld_reg[0] <= s0_vld_reg;
            for (int k = 1; k <= dbbm_pkg::Q_W; k++)
                side_vld_reg[k] <= side_vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            side_reg[0] <= s0_side_reg;
            for (int k = 1; k <= dbbm_pkg::Q_W; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    dbbm_div u_div_x (
        .clk (clk), .en (pipe_en), .num (numx_reg), .den (denx_reg), .neg (negx_reg), .q (q_x)
    );
    dbbm_div u_div_y (
        .clk (clk), .en (pipe_en), .num (numy_reg), .den (deny_reg), .neg (negy_reg), .q (q_y)
    );
    dbbm_div u_div_z (
        .clk (clk), .en (pipe_en), .num (numz_reg), .den (denz_reg), .neg (1'b0), .q (q_z)
    );
    dbbm_div u_div_avg (
        .clk (clk), .en (pipe_en), .num (numa_reg), .den (dena_reg), .neg (1'b0), .q (q_a)
    );

    assign side_out = side_reg[dbbm_pkg::Q_W];

    // Coefficient writes land in order with the pixels entering the lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < dbbm_pkg::NUM_COEF; k++)
                coef_reg[k] <= (k == 0 || k == 5 || k == 10)
                             ? dbbm_pkg::COEF_W'(dbbm_pkg::ONE_Q16) : '0;
        end
        else if (pipe_en && side_vld_reg[dbbm_pkg::Q_W] && side_out.is_coef
                 && side_out.idx < dbbm_pkg::COEF_IDX_W'(dbbm_pkg::NUM_COEF))
        begin
            coef_reg[side_out.idx] <= side_out.val;
        end
    end

    // Item state travels beside the transform lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < dbbm_pkg::XF_LAT; k++)
                post_vld_reg[k] <= 1'b0;
        end
        else if (pipe_en)
        begin
            post_vld_reg[0] <= side_vld_reg[dbbm_pkg::Q_W] && !side_out.is_coef;
            for (int k = 1; k < dbbm_pkg::XF_LAT; k++)
                post_vld_reg[k] <= post_vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            post_reg[0].col   <= side_out.col;
            post_reg[0].row   <= side_out.row;
            post_reg[0].ok    <= side_out.ok;
            post_reg[0].valid <= side_out.valid;
            post_reg[0].avg   <= q_a[dbbm_pkg::DEPTH_W-1:0];
            for (int k = 1; k < dbbm_pkg::XF_LAT; k++)
                post_reg[k] <= post_reg[k-1];
        end
    end

    assign pc_vec = {q_z, q_y, q_x};

    for (genvar r = 0; r < 3; r++) begin : g_lane
        dbbm_xform_lane u_lane (
            .clk  (clk),
            .en   (pipe_en),
            .coef ({coef_reg[4*r+3], coef_reg[4*r+2], coef_reg[4*r+1], coef_reg[4*r]}),
            .pc   (pc_vec),
            .obj  (obj[r])
        );
    end

    dbbm_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_vld    (post_vld_reg[dbbm_pkg::XF_LAT-1]),
        .info      (post_reg[dbbm_pkg::XF_LAT-1]),
        .obj_x     (obj[0]),
        .obj_y     (obj[1]),
        .obj_z     (obj[2]),
        .box_x_min (box_x_min_reg),
        .box_y_max (box_y_max_reg),
        .box_z_min (box_z_min_reg),
        .res_vld   (m_tvalid),
        .res_data  (m_tdata)
    );

`ifndef SYNTHESIS
    // Skid fills only while the pipeline is held
    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> !$past(pipe_en))
        else $error("skid filled while pipeline advanced");

    // Box hit requires a valid depth
    a_inside_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[113]) |-> m_tdata[24])
        else $error("inside_box without depth_valid");

    // Rejected pixels carry a zero point
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[24]) |-> (m_tdata[112:41] == '0))
        else $error("rejected pixel has nonzero point");
`endif

endmodule

`default_nettype wire

@@ design/dbbm_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per pipeline stage, sign applied at the end
module dbbm_div (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic [dbbm_pkg::NUM_W-1:0]        num,
    input  wire logic [dbbm_pkg::DEN_W-1:0]        den,
    input  wire logic                              neg,
    output logic signed [dbbm_pkg::PC_W-1:0]       q
);

    logic [dbbm_pkg::NUM_W-1:0] rem_s [dbbm_pkg::Q_W+1];
    logic [dbbm_pkg::DEN_W-1:0] den_s [dbbm_pkg::Q_W+1];
    logic [dbbm_pkg::Q_W-1:0]   quo_s [dbbm_pkg::Q_W+1];
    logic                       neg_s [dbbm_pkg::Q_W+1];

    assign rem_s[0] = num;
    assign den_s[0] = den;
    assign quo_s[0] = '0;
    assign neg_s[0] = neg;

    for (genvar k = 0; k < dbbm_pkg::Q_W; k++) begin : g_stage
        logic [dbbm_pkg::NUM_W-1:0] dsh;
        logic                       ge;

        assign dsh = dbbm_pkg::NUM_W'(den_s[k]) << (dbbm_pkg::Q_W - 1 - k);
        assign ge  = rem_s[k] >= dsh;

        // Subtract the shifted divisor when it fits
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_s[k+1] <= ge ? rem_s[k] - dsh : rem_s[k];
                quo_s[k+1] <= {quo_s[k][dbbm_pkg::Q_W-2:0], ge};
                den_s[k+1] <= den_s[k];
                neg_s[k+1] <= neg_s[k];
            end
        end
    end

    // Restore sign
    always_comb
    begin
        if (neg_s[dbbm_pkg::Q_W])
            q = -$signed({1'b0, quo_s[dbbm_pkg::Q_W]});
        else
            q = $signed({1'b0, quo_s[dbbm_pkg::Q_W]});
    end

endmodule

`default_nettype wire

@@ design/dbbm_xform_lane.sv @@
`default_nettype none

// One row of the rigid transform: multiply, sum, round, saturate
module dbbm_xform_lane (
    input  wire logic                                  clk,
    input  wire logic                                  en,
    input  wire logic [3:0][dbbm_pkg::COEF_W-1:0]      coef,
    input  wire logic [2:0][dbbm_pkg::PC_W-1:0]        pc,
    output logic signed [dbbm_pkg::COORD_W-1:0]        obj
);

    logic signed [dbbm_pkg::PROD_W-1:0] prod_reg [3];
    logic signed [dbbm_pkg::ACC_W-1:0]  t16_reg;
    logic signed [dbbm_pkg::ACC_W-1:0]  acc_reg;
    logic [dbbm_pkg::RND_W-1:0]         rnd_reg;
    logic                               neg_reg;
    logic signed [dbbm_pkg::COORD_W-1:0] obj_reg;

    logic [dbbm_pkg::ACC_W-1:0]   mag;
    logic [dbbm_pkg::ACC_W-1:0]   mag_rnd;
    logic signed [dbbm_pkg::COORD_W-1:0] obj_next;

    // Multiply each coefficient by its camera coordinate
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
                prod_reg[j] <= $signed(coef[j]) * $signed(pc[j]);
            t16_reg <= dbbm_pkg::ACC_W'($signed(coef[3])) <<< 4;
        end
    end

    // Sum products and translation
    always_ff @(posedge clk)
    begin
        if (en)
            acc_reg <= dbbm_pkg::ACC_W'(prod_reg[0]) + dbbm_pkg::ACC_W'(prod_reg[1])
                     + dbbm_pkg::ACC_W'(prod_reg[2]) + t16_reg;
    end

    // Round magnitude to nearest, ties away from zero
    always_comb
    begin
        mag     = acc_reg[dbbm_pkg::ACC_W-1] ? dbbm_pkg::ACC_W'(-acc_reg)
                                             : dbbm_pkg::ACC_W'(acc_reg);
        mag_rnd = mag + dbbm_pkg::ACC_W'(dbbm_pkg::ONE_Q16 / 2);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rnd_reg <= mag_rnd[dbbm_pkg::ACC_W-1:dbbm_pkg::FRAC_W];
            neg_reg <= acc_reg[dbbm_pkg::ACC_W-1];
        end
    end

    // Saturate to the coordinate range
    always_comb
    begin
        if (!neg_reg && rnd_reg > dbbm_pkg::RND_W'((1 << (dbbm_pkg::COORD_W - 1)) - 1))
            obj_next = {1'b0, {(dbbm_pkg::COORD_W-1){1'b1}}};
        else if (neg_reg && rnd_reg > dbbm_pkg::RND_W'(1 << (dbbm_pkg::COORD_W - 1)))
            obj_next = {1'b1, {(dbbm_pkg::COORD_W-1){1'b0}}};
        else if (neg_reg)
            obj_next = -$signed(rnd_reg[dbbm_pkg::COORD_W-1:0]);
        else
            obj_next = $signed(rnd_reg[dbbm_pkg::COORD_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            obj_reg <= obj_next;
    end

    assign obj = obj_reg;

endmodule

`default_nettype wire

@@ design/dbbm_merge.sv @@
`default_nettype none

// Combine lane results: mask invalid pixels, test box, pack the output beat
module dbbm_merge (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  wire logic                                in_vld,
    input  wire dbbm_pkg::post_t                     info,
    input  wire logic signed [dbbm_pkg::COORD_W-1:0] obj_x,
    input  wire logic signed [dbbm_pkg::COORD_W-1:0] obj_y,
    input  wire logic signed [dbbm_pkg::COORD_W-1:0] obj_z,
    input  wire logic signed [dbbm_pkg::BOX_W-1:0]   box_x_min,
    input  wire logic signed [dbbm_pkg::BOX_W-1:0]   box_y_max,
    input  wire logic signed [dbbm_pkg::BOX_W-1:0]   box_z_min,
    output logic                                     res_vld,
    output logic [dbbm_pkg::OUT_DATA_W-1:0]          res_data
);

    logic                                 vld_reg;
    logic [dbbm_pkg::OUT_DATA_W-1:0]      data_reg;
    logic signed [dbbm_pkg::COORD_W-1:0]  bx, by, bz;
    logic signed [dbbm_pkg::COORD_W-1:0]  ox, oy, oz;
    logic [dbbm_pkg::DEPTH_W-1:0]         avg;
    logic                                 in_box;

    // Scale box limits to 1/16 mm
    assign bx = dbbm_pkg::COORD_W'(box_x_min) <<< 4;
    assign by = dbbm_pkg::COORD_W'(box_y_max) <<< 4;
    assign bz = dbbm_pkg::COORD_W'(box_z_min) <<< 4;

    always_comb
    begin
        ox     = info.valid ? obj_x : '0;
        oy     = info.valid ? obj_y : '0;
        oz     = info.valid ? obj_z : '0;
        avg    = info.ok ? info.avg : '0;
        in_box = info.valid && (obj_x > bx) && (obj_y < by) && (obj_z > bz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= {6'b0, in_box, oz, oy, ox, avg, info.valid, info.row, info.col};
    end

    assign res_vld  = vld_reg;
    assign res_data = data_reg;

endmodule

`default_nettype wire

@@ dv/depth_backproject_box_mask_tb.sv @@
`timescale 1ns / 100ps

typedef struct {
    bit [11:0] col;
    bit [11:0] row;
    bit        valid;
    bit [15:0] avg;
    bit [23:0] x;
    bit [23:0] y;
    bit [23:0] z;
    bit        in_box;
} point_result_t;

class box_mask_scoreboard;
    int unsigned   frames;
    int unsigned   max_mm;
    int            box_x;
    int            box_y;
    int            box_z;
    int            coefs[12];
    point_result_t pending[$];
    int            errors;
    int            pixels;
    int            coef_writes;
    int            inside_hits;
    int            valid_hits;

    function new();
        frames = 1;
        max_mm = 1500;
        box_x  = -60;
        box_y  = 30;
        box_z  = 390;
        foreach (coefs[i])
            coefs[i] = 0;
        coefs[0]  = dbbm_pkg::ONE_Q16;
        coefs[5]  = dbbm_pkg::ONE_Q16;
        coefs[10] = dbbm_pkg::ONE_Q16;
        errors = 0;
    endfunction

    function void set_reg(dbbm_pkg::cfg_reg_t idx, bit [12:0] d);
        case (idx)
            dbbm_pkg::REG_FRAME_COUNT: frames = d[2:0];
            dbbm_pkg::REG_MAX_DEPTH:   max_mm = d;
            dbbm_pkg::REG_BOX_X_MIN:   box_x  = int'($signed(d));
            dbbm_pkg::REG_BOX_Y_MAX:   box_y  = int'($signed(d));
            dbbm_pkg::REG_BOX_Z_MIN:   box_z  = int'($signed(d));
            default: ;
        endcase
    endfunction

    // Round to nearest, ties away from zero; den is positive
    function longint round_div(longint num, longint den);
        if (num >= 0)
            return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function longint clamp24(longint v);
        if (v > 64'sd8388607)
            return 64'sd8388607;
        if (v < -64'sd8388608)
            return -64'sd8388608;
        return v;
    endfunction

    // Predict the result of one accepted input beat
    function void note_beat(bit cmd, bit [dbbm_pkg::IN_DATA_W-1:0] d);
        point_result_t r;
        longint        n;
        longint        sum;
        longint        samp;
        longint        pc[3];
        longint        obj[3];
        longint        acc;
        bit            ok;
        if (cmd == dbbm_pkg::CMD_COEF) begin
            coef_writes++;
            if (d[91:88] < dbbm_pkg::NUM_COEF)
                coefs[d[91:88]] = int'($signed(d[123:92]));
            return;
        end
        pixels++;
        n = frames;
        if (n < 1)
            n = 1;
        if (n > dbbm_pkg::MAX_FRAMES)
            n = dbbm_pkg::MAX_FRAMES;
        if (n > dbbm_pkg::NUM_SAMPLES)
            n = dbbm_pkg::NUM_SAMPLES;
        sum = 0;
        ok  = 1;
        for (int i = 0; i < n; i++) begin
            samp = d[24 + 16 * i +: 16];
            if (samp == 0)
                ok = 0;
            sum += samp;
        end
        r.col    = d[11:0];
        r.row    = d[23:12];
        r.avg    = ok ? 16'(sum / n) : 16'd0;
        r.valid  = ok && !(sum > longint'(max_mm) * 10 * n);
        r.x      = 0;
        r.y      = 0;
        r.z      = 0;
        r.in_box = 0;
        if (r.valid) begin
            pc[0] = round_div((longint'(r.col) * 1000 - dbbm_pkg::CX_MILLI) * sum * 16,
                              longint'(dbbm_pkg::FX_DEN) * n);
            pc[1] = round_div((longint'(r.row) * 1000 - dbbm_pkg::CY_MILLI) * sum * 16,
                              longint'(dbbm_pkg::FY_DEN) * n);
            pc[2] = round_div(sum * 16, dbbm_pkg::Z_DEN * n);
            for (int i = 0; i < 3; i++) begin
                acc = longint'(coefs[i * 4 + 3]) * 16;
                for (int j = 0; j < 3; j++)
                    acc += longint'(coefs[i * 4 + j]) * pc[j];
                obj[i] = clamp24(round_div(acc, dbbm_pkg::ONE_Q16));
            end
            r.x = obj[0][23:0];
            r.y = obj[1][23:0];
            r.z = obj[2][23:0];
            r.in_box = obj[0] > longint'(box_x) * 16 && obj[1] < longint'(box_y) * 16
                       && obj[2] > longint'(box_z) * 16;
            valid_hits++;
            if (r.in_box)
                inside_hits++;
        end
        pending = {pending, r};
    endfunction

    task report(string field, longint got, longint want);
        $display("%0t: %s got %0h expected %0h", $realtime, field, got, want);
        errors++;
    endtask

    // Compare one output beat with the oldest prediction
    task check_beat(bit [dbbm_pkg::OUT_DATA_W-1:0] d);
        point_result_t e;
        if (pending.size() == 0) begin
            report("unexpected beat", d[63:0], 0);
            return;
        end
        e = pending.pop_front();
        if (d[11:0] != e.col)      report("out_col", d[11:0], e.col);
        if (d[23:12] != e.row)     report("out_row", d[23:12], e.row);
        if (d[24] != e.valid)      report("depth_valid", d[24], e.valid);
        if (d[40:25] != e.avg)     report("avg_depth", d[40:25], e.avg);
        if (d[64:41] != e.x)       report("obj_x", d[64:41], e.x);
        if (d[88:65] != e.y)       report("obj_y", d[88:65], e.y);
        if (d[112:89] != e.z)      report("obj_z", d[112:89], e.z);
        if (d[113] != e.in_box)    report("inside_box", d[113], e.in_box);
    endtask
endclass

module depth_backproject_box_mask_tb;
    logic                            clk;
    logic                            rst_n;
    logic [dbbm_pkg::IN_DATA_W-1:0]  s_tdata;
    logic                            s_tuser;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [dbbm_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic                            cfg_we;
    logic [dbbm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [dbbm_pkg::CFG_DATA_W-1:0] cfg_data;

    box_mask_scoreboard    sb;
    bit                    steady;
    int                    quiet_cycles;

    depth_backproject_box_mask dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Stall the result side at random, except in steady stretches
    always @(posedge clk)
    begin
        m_tready <= steady || $urandom_range(99) >= 16;
    end

    // Watch both streams; hand beats to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_tvalid && s_tready)
                sb.note_beat(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_beat(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= 3000) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task send_beat(bit cmd, bit [dbbm_pkg::IN_DATA_W-1:0] d);
        while (!steady && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task send_pixel(bit [11:0] col, bit [11:0] row, bit [15:0] d0, bit [15:0] d1,
                    bit [15:0] d2, bit [15:0] d3);
        send_beat(dbbm_pkg::CMD_PIXEL, {4'($urandom), 32'($urandom), 4'($urandom),
                                        d3, d2, d1, d0, row, col});
    endtask

    task send_coef(bit [3:0] idx, bit [31:0] val);
        send_beat(dbbm_pkg::CMD_COEF, {4'd0, val, idx, 64'({$urandom, $urandom}),
                                       24'($urandom)});
    endtask

    // Let the pipeline drain before touching registers
    task drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (32) @(posedge clk);
    endtask

    task write_reg(dbbm_pkg::cfg_reg_t idx, bit [12:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, d);
    endtask

    function bit [15:0] pick_depth(int unsigned limit_mm);
        int unsigned k;
        k = $urandom_range(99);
        if (k < 6)
            return 16'd0;
        if (k < 60)
            return 16'($urandom_range(limit_mm * 12 + 10, 3000));
        return 16'($urandom_range(65535, 1));
    endfunction

    task random_beats(int count);
        bit [31:0] v;
        for (int i = 0; i < count; i++) begin
            steady = (i >= count / 3 && i < count / 2);
            if ($urandom_range(99) < 6) begin
                case ($urandom_range(3))
                    0: v = $urandom;
                    1: v = 32'($signed(dbbm_pkg::ONE_Q16)) + 32'($urandom_range(16384))
                           - 32'd8192;
                    2: v = 32'($urandom_range(40000)) - 32'd20000;
                    default: v = 32'($urandom_range(131072)) - 32'd65536;
                endcase
                send_coef(4'($urandom), v);
            end
            else
                send_pixel(12'($urandom), 12'($urandom), pick_depth(sb.max_mm),
                           pick_depth(sb.max_mm), pick_depth(sb.max_mm),
                           pick_depth(sb.max_mm));
        end
        steady = 0;
    endtask

    initial
    begin
        bit [2:0]  fc_set[6]   = '{3'd2, 3'd4, 3'd0, 3'd7, 3'd3, 3'd1};
        bit [12:0] maxd_set[6] = '{13'd6553, 13'd0, 13'd8191, 13'd3000, 13'd1000, 13'd1500};
        sb        = new();
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = dbbm_pkg::REG_FRAME_COUNT;
        cfg_data  = '0;
        steady    = 0;
        quiet_cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes under reset settings
        send_pixel(12'd0, 12'd0, 16'd4000, 16'd0, 16'd0, 16'd0);
        send_pixel(12'd4095, 12'd4095, 16'd15000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(12'd954, 12'd533, 16'd0, 16'd5000, 16'd5000, 16'd5000);
        send_pixel(12'd100, 12'd900, 16'hFFFF, 16'd1, 16'd1, 16'd1);
        send_pixel(12'd960, 12'd500, 16'd15001, 16'd0, 16'd0, 16'd0);
        send_pixel(12'd960, 12'd500, 16'd1, 16'd0, 16'd0, 16'd0);
        // Out-of-range coefficient indexes are dropped
        send_coef(4'd12, 32'hFFFF_FFFF);
        send_coef(4'd15, 32'h8000_0000);
        send_pixel(12'd1200, 12'd300, 16'd8000, 16'd0, 16'd0, 16'd0);
        // Saturating transform: extreme coefficients
        send_coef(4'd0, 32'h7FFF_FFFF);
        send_coef(4'd5, 32'h8000_0000);
        send_coef(4'd11, 32'h7FFF_FFFF);
        send_pixel(12'd4095, 12'd0, 16'd15000, 16'd0, 16'd0, 16'd0);
        send_pixel(12'd0, 12'd4095, 16'd15000, 16'd0, 16'd0, 16'd0);
        // Back to identity rotation, then a small negative x translation
        send_coef(4'd0, 32'(dbbm_pkg::ONE_Q16));
        send_coef(4'd5, 32'(dbbm_pkg::ONE_Q16));
        send_coef(4'd11, 32'd0);
        send_coef(4'd3, 32'hFFFF_FFF0);
        send_pixel(12'd900, 12'd560, 16'd5000, 16'd7, 16'd9, 16'd11);
        drain();

        // Four frames: a late zero sample, then a full set
        write_reg(dbbm_pkg::REG_FRAME_COUNT, 13'd4);
        send_pixel(12'd950, 12'd530, 16'd6000, 16'd6001, 16'd6002, 16'd0);
        send_pixel(12'd950, 12'd530, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(12'd950, 12'd530, 16'd6000, 16'd6001, 16'd6002, 16'd6003);
        send_coef(4'd3, 32'd0);
        drain();

        // Random phases, each under its own register set
        for (int p = 0; p < 6; p++) begin
            write_reg(dbbm_pkg::REG_FRAME_COUNT, 13'(fc_set[p]));
            write_reg(dbbm_pkg::REG_MAX_DEPTH, maxd_set[p]);
            write_reg(dbbm_pkg::REG_BOX_X_MIN,
                      p == 1 ? 13'h1000 : 13'($urandom_range(400)) - 13'd200);
            write_reg(dbbm_pkg::REG_BOX_Y_MAX,
                      p == 1 ? 13'h0FFF : 13'($urandom_range(400)) - 13'd200);
            write_reg(dbbm_pkg::REG_BOX_Z_MIN, p == 1 ? 13'h1000 :
                      (p == 3 ? 13'h0FFF : 13'($urandom_range(1200))));
            if (p == 4)
                write_reg(dbbm_pkg::REG_BOX_X_MIN, 13'($urandom));
            random_beats(140);
            drain();
        end

        $display("Covered %0d pixels (%0d valid, %0d inside box) and %0d coefficient writes",
                 sb.pixels, sb.valid_hits, sb.inside_hits, sb.coef_writes);
        $display("over six register settings plus directed extremes; %0d mismatches",
                 sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
